// ===== hw/rtl/arpc_pkg.sv =====
// Shared types and constants of the ARP cache table.
package arpc_pkg;

	localparam int IP_W      = 32;
	localparam int MAC_W     = 48;
	localparam int TICK_W    = 32;
	localparam int TIMEOUT_W = 16;
	localparam int SLOT_W    = 6;

	localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd15;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_TICK   = 2'd2
	} opcode_t;

	typedef enum logic [2:0] {
		ST_CLEAR = 3'd0,
		ST_IDLE  = 3'd1,
		ST_SCAN  = 3'd2,
		ST_DRAIN = 3'd3,
		ST_DONE  = 3'd4
	} state_t;

	// One table row as held in the entry memory.
	typedef struct packed {
		logic              valid;
		logic [IP_W-1:0]   ip;
		logic [MAC_W-1:0]  mac;
		logic [TICK_W-1:0] added;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;
		logic start;
		logic issue;
		logic publish;
	} ctl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic idx_last;
		logic out_free;
	} ctl_sts_t;

endpackage

// ===== hw/rtl/arpc_req_if.sv =====
// Request channel: one table operation per item.
interface arpc_req_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [31:0] ip_addr;
	logic [47:0] mac_addr;

	modport source (output valid, output opcode, output ip_addr, output mac_addr, input ready);
	modport sink (input valid, input opcode, input ip_addr, input mac_addr, output ready);
endinterface

// ===== hw/rtl/arpc_rsp_if.sv =====
// Response channel: one result item per request item.
interface arpc_rsp_if;
	logic        valid;
	logic        ready;
	logic        hit;
	logic [47:0] mac_out;
	logic        stored;
	logic [5:0]  slot;

	modport source (output valid, output hit, output mac_out, output stored, output slot,
		input ready);
	modport sink (input valid, input hit, input mac_out, input stored, input slot,
		output ready);
endinterface

// ===== hw/rtl/arpc_ctrl.sv =====
// Controller state machine: clearing pass, item accept, table scan, result hand-off.
module arpc_ctrl
	import arpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ctl_sts_t sts,
	output ctl_cmd_t cmd
);

	state_t state_q;
	state_t state_d;

	// Advance the state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (sts.idx_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (sts.idx_last) state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	// Outputs
	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr = 1'b1;
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			ST_SCAN: begin
				cmd.issue = 1'b1;
			end
			ST_DRAIN: begin
			end
			ST_DONE: begin
				cmd.publish = sts.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ===== hw/rtl/arpc_datapath.sv =====
// Datapath: entry memory, scan counter, row evaluation, tick counter and result register.
module arpc_datapath
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  ctl_cmd_t             cmd,
	output ctl_sts_t             sts,
	input  logic [1:0]           opcode,
	input  logic [IP_W-1:0]      ip_addr,
	input  logic [MAC_W-1:0]     mac_addr,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic                 hit,
	output logic [MAC_W-1:0]     mac_out,
	output logic                 stored,
	output logic [SLOT_W-1:0]    slot
);

	localparam int IDX_W = $clog2(ENTRIES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(ENTRIES - 1);

	entry_t               mem_q [ENTRIES];
	logic [IDX_W-1:0]     idx_q;
	logic                 v_s1;
	logic [IDX_W-1:0]     idx_s1;
	entry_t               row_s1;
	opcode_t              op_q;
	logic [IP_W-1:0]      ip_q;
	logic [MAC_W-1:0]     mac_q;
	logic [TICK_W-1:0]    now_q;
	logic [TIMEOUT_W-1:0] timeout_q;
	logic                 hit_q;
	logic [MAC_W-1:0]     mac_acc_q;
	logic                 stored_q;
	logic [IDX_W-1:0]     slot_acc_q;
	logic                 out_valid_q;
	logic                 out_hit_q;
	logic [MAC_W-1:0]     out_mac_q;
	logic                 out_stored_q;
	logic [SLOT_W-1:0]    out_slot_q;

	logic                 we;
	logic [IDX_W-1:0]     waddr;
	entry_t               wdata;
	logic                 ev_hit;
	logic                 ev_store;
	logic                 ev_expire;
	logic [TICK_W-1:0]    age;
	logic [SLOT_W+IDX_W-1:0] slot_ext;

	assign sts.idx_last = (idx_q == IDX_LAST);
	assign sts.out_free = !out_valid_q || out_ready;

	// Evaluate the row read in the previous cycle
	assign age = now_q - row_s1.added;
	always_comb begin
		ev_hit    = 1'b0;
		ev_store  = 1'b0;
		ev_expire = 1'b0;
		case (op_q)
			OP_LOOKUP: ev_hit    = v_s1 && row_s1.valid && (row_s1.ip == ip_q);
			OP_INSERT: ev_store  = v_s1 && !row_s1.valid && !stored_q;
			OP_TICK:   ev_expire = v_s1 && row_s1.valid && (age > TICK_W'(timeout_q));
			default: begin
			end
		endcase
	end

	// Write port: clearing pass, insert or expiry
	always_comb begin
		we    = 1'b0;
		waddr = idx_s1;
		wdata = row_s1;
		if (cmd.clr) begin
			we          = 1'b1;
			waddr       = idx_q;
			wdata       = row_s1;
			wdata.valid = 1'b0;
		end else if (ev_store) begin
			we          = 1'b1;
			wdata.valid = 1'b1;
			wdata.ip    = ip_q;
			wdata.mac   = mac_q;
			wdata.added = now_q;
		end else if (ev_expire) begin
			we          = 1'b1;
			wdata.valid = 1'b0;
		end
	end

	// Entry memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (we) mem_q[waddr] <= wdata;
		if (cmd.issue) begin
			row_s1 <= mem_q[idx_q];
			idx_s1 <= idx_q;
		end
	end

	// Hold the item payload
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			op_q  <= opcode_t'(opcode);
			ip_q  <= ip_addr;
			mac_q <= mac_addr;
		end
	end

	// Scan counter, tick counter, timeout register, accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			v_s1       <= 1'b0;
			now_q      <= '0;
			timeout_q  <= TIMEOUT_RESET;
			hit_q      <= 1'b0;
			mac_acc_q  <= '0;
			stored_q   <= 1'b0;
			slot_acc_q <= '0;
		end else begin
			v_s1 <= cmd.issue;
			if (cfg_we) timeout_q <= cfg_wdata;
			if (cmd.start) begin
				idx_q      <= '0;
				hit_q      <= 1'b0;
				mac_acc_q  <= '0;
				stored_q   <= 1'b0;
				slot_acc_q <= '0;
				if (opcode_t'(opcode) == OP_TICK) now_q <= now_q + TICK_W'(1);
			end else if (cmd.clr || cmd.issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (ev_hit) begin
				hit_q      <= 1'b1;
				mac_acc_q  <= row_s1.mac;
				slot_acc_q <= idx_s1;
			end
			if (ev_store) begin
				stored_q   <= 1'b1;
				slot_acc_q <= idx_s1;
			end
		end
	end

	assign slot_ext = {{SLOT_W{1'b0}}, slot_acc_q};

	// Output register, loaded once per item and held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.publish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.publish) begin
			out_hit_q    <= hit_q;
			out_mac_q    <= mac_acc_q;
			out_stored_q <= stored_q;
			out_slot_q   <= slot_ext[SLOT_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign hit       = out_hit_q;
	assign mac_out   = out_mac_q;
	assign stored    = out_stored_q;
	assign slot      = out_slot_q;

endmodule

// ===== hw/rtl/arp_cache_table_top.sv =====
// ARP cache table: IP-to-MAC entries with insertion-time aging.
//
// Each request item (lookup, insert or one-second tick) yields exactly one response item.
// The table sits in a single-port-read memory of ENTRIES rows and every item walks it
// one row per cycle, so a new item is accepted only once the walk and the hand-off are done;
// that walk through the one read port sets the rate. A lookup reports the highest matching
// valid row, an insert takes the lowest free row, and a tick ages out rows whose wrapped
// age exceeds the configured timeout. After reset a clearing pass invalidates every row
// before the first item is taken; cfg_we writes the timeout at any time the
// block is idle, including during that pass. A finished response waits in an output
// register, so the next item is accepted while it is still pending.
module arp_cache_table_top
	import arpc_pkg::*;
#(
	parameter int ENTRIES = 64
)
(
	input  logic                 clk,
	input  logic                 arst_n,
	arpc_req_if.sink             req,
	arpc_rsp_if.source           rsp,
	input  logic                 cfg_we,
	input  logic [TIMEOUT_W-1:0] cfg_wdata
);

	ctl_cmd_t cmd;
	ctl_sts_t sts;

	arpc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	arpc_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.opcode    (req.opcode),
		.ip_addr   (req.ip_addr),
		.mac_addr  (req.mac_addr),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.hit       (rsp.hit),
		.mac_out   (rsp.mac_out),
		.stored    (rsp.stored),
		.slot      (rsp.slot)
	);

endmodule

// ===== dv/arp_cache_table_top_tb.sv =====
// Testbench for the ARP cache table: directed and random table operations with aging checks.
`timescale 1ns / 100ps

module arp_cache_table_top_tb;
	import arpc_pkg::*;

	localparam int ENTRIES       = 64;
	localparam int POOL_N        = 12;
	localparam int PHASE_ITEMS   = 260;
	localparam int LAST_PHASE    = 7;
	localparam int HOLD_PHASE    = 3;
	localparam int CALM_PHASE    = 5;
	localparam int HOLD_CYCLES   = 400;
	localparam int IDLE_PCT      = 38;
	localparam int SETTLE_LIMIT  = 6000;
	localparam int REPORT_LIMIT  = 10;
	localparam int DIRECTED_N    = 17;

	// The opcode value that the block ignores.
	localparam logic [1:0] OP_RSVD = 2'd3;

	typedef struct packed {
		logic [1:0]       opcode;
		logic [IP_W-1:0]  ip_addr;
		logic [MAC_W-1:0] mac_addr;
	} arp_req_t;

	typedef struct packed {
		logic              hit;
		logic [MAC_W-1:0]  mac_out;
		logic              stored;
		logic [SLOT_W-1:0] slot;
	} arp_rsp_t;

	// Optional fixed result that overrides the prediction for one item.
	typedef struct packed {
		logic     pinned;
		arp_rsp_t rsp;
	} pinned_rsp_t;

	typedef struct packed {
		arp_req_t    req;
		pinned_rsp_t want;
	} directed_row_t;

	localparam arp_rsp_t         NO_RESULT = '0;
	localparam logic [MAC_W-1:0] MAC_ONES  = '1;

	// Extremes, every opcode, duplicates, ignored opcode, then rows left to the predictor.
	localparam directed_row_t DIRECTED_ROWS [DIRECTED_N] = '{
		'{'{OP_LOOKUP, 32'h0000_0000, 48'h0}, '{1'b1, NO_RESULT}},
		'{'{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0}, '{1'b1, NO_RESULT}},
		'{'{OP_INSERT, 32'h0000_0000, 48'h0}, '{1'b1, '{1'b0, 48'h0, 1'b1, 6'd0}}},
		'{'{OP_INSERT, 32'hFFFF_FFFF, MAC_ONES}, '{1'b1, '{1'b0, 48'h0, 1'b1, 6'd1}}},
		'{'{OP_LOOKUP, 32'hFFFF_FFFF, 48'h0}, '{1'b1, '{1'b1, MAC_ONES, 1'b0, 6'd1}}},
		'{'{OP_LOOKUP, 32'h0000_0000, MAC_ONES}, '{1'b1, '{1'b1, 48'h0, 1'b0, 6'd0}}},
		'{'{OP_RSVD, 32'hFFFF_FFFF, MAC_ONES}, '{1'b1, NO_RESULT}},
		'{'{OP_TICK, 32'hFFFF_FFFF, MAC_ONES}, '{1'b1, NO_RESULT}},
		'{'{OP_INSERT, 32'h0A00_0001, 48'h0123_4567_89AB}, '{1'b1, '{1'b0, 48'h0, 1'b1, 6'd2}}},
		'{'{OP_INSERT, 32'h0A00_0001, 48'hA5A5_A5A5_A5A5}, '{1'b1, '{1'b0, 48'h0, 1'b1, 6'd3}}},
		'{'{OP_LOOKUP, 32'h0A00_0001, 48'h0},
			'{1'b1, '{1'b1, 48'hA5A5_A5A5_A5A5, 1'b0, 6'd3}}},
		'{'{OP_RSVD, 32'h0A00_0001, 48'h5A5A_5A5A_5A5A}, '{1'b1, NO_RESULT}},
		'{'{OP_LOOKUP, 32'h0A00_0001, 48'h0}, '{1'b0, NO_RESULT}},
		'{'{OP_LOOKUP, 32'h0A00_0002, 48'h0}, '{1'b0, NO_RESULT}},
		'{'{OP_INSERT, 32'hC0A8_0101, 48'h5A5A_5A5A_5A5A}, '{1'b0, NO_RESULT}},
		'{'{OP_TICK, 32'h0000_0000, 48'h0}, '{1'b0, NO_RESULT}},
		'{'{OP_LOOKUP, 32'hC0A8_0101, 48'h0}, '{1'b0, NO_RESULT}}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [TIMEOUT_W-1:0] cfg_wdata;

	arpc_req_if req_ch();
	arpc_rsp_if rsp_ch();

	arp_cache_table_top #(
		.ENTRIES(ENTRIES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req_ch),
		.rsp      (rsp_ch),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	// Mirror of the table contents and timer.
	bit                   row_valid [ENTRIES];
	logic [IP_W-1:0]      row_ip    [ENTRIES];
	logic [MAC_W-1:0]     row_mac   [ENTRIES];
	logic [TICK_W-1:0]    row_added [ENTRIES];
	logic [TICK_W-1:0]    now_tick;
	logic [TIMEOUT_W-1:0] age_limit;

	arp_rsp_t    results_due [$];
	pinned_rsp_t pinned_q    [$];
	logic [IP_W-1:0] ip_pool [POOL_N];
	int unsigned err_count;
	int          phase_no;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Give up after a generous fixed time.
	initial begin
		#40_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	function automatic void log_fault(string msg);
		err_count++;
		if (err_count <= REPORT_LIMIT) begin
			$display("%0t: %s", $realtime, msg);
		end
	endfunction

	// Apply one table operation to the mirror and return the result it yields.
	function automatic arp_rsp_t apply_table_op(arp_req_t r);
		arp_rsp_t          res;
		bit                placed;
		logic [TICK_W-1:0] age;
		res = '0;
		placed = 1'b0;
		case (r.opcode)
			OP_LOOKUP: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (row_valid[i] && row_ip[i] == r.ip_addr) begin
						res.hit = 1'b1;
						res.mac_out = row_mac[i];
						res.slot = SLOT_W'(i);
					end
				end
			end
			OP_INSERT: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (!placed && !row_valid[i]) begin
						placed = 1'b1;
						row_valid[i] = 1'b1;
						row_ip[i] = r.ip_addr;
						row_mac[i] = r.mac_addr;
						row_added[i] = now_tick;
						res.stored = 1'b1;
						res.slot = SLOT_W'(i);
					end
				end
			end
			OP_TICK: begin
				now_tick = now_tick + TICK_W'(1);
				for (int i = 0; i < ENTRIES; i++) begin
					age = now_tick - row_added[i];
					if (row_valid[i] && age > TICK_W'(age_limit)) begin
						row_valid[i] = 1'b0;
					end
				end
			end
			default: ;
		endcase
		return res;
	endfunction

	// Check results against the oldest expectation, then predict each accepted item.
	always @(posedge clk) begin : track_table_ops
		arp_rsp_t    got;
		arp_rsp_t    want;
		pinned_rsp_t pin;
		if (rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
			got = '{rsp_ch.hit, rsp_ch.mac_out, rsp_ch.stored, rsp_ch.slot};
			if (results_due.size() == 0) begin
				log_fault($sformatf("result with none outstanding: hit=%0b mac=%h stored=%0b slot=%0d",
					got.hit, got.mac_out, got.stored, got.slot));
			end else begin
				want = results_due.pop_front();
				if (got.hit !== want.hit || got.mac_out !== want.mac_out
						|| got.stored !== want.stored || got.slot !== want.slot) begin
					log_fault($sformatf({"mismatch: hit %0b/%0b mac %h/%h stored %0b/%0b",
						" slot %0d/%0d (expected/actual)"},
						want.hit, got.hit, want.mac_out, got.mac_out,
						want.stored, got.stored, want.slot, got.slot));
				end
			end
		end
		if (req_ch.valid && req_ch.ready === 1'b1) begin
			want = apply_table_op('{req_ch.opcode, req_ch.ip_addr, req_ch.mac_addr});
			pin = pinned_q.pop_front();
			if (pin.pinned) begin
				want = pin.rsp;
			end
			results_due.push_back(want);
		end
	end

	// Drive ready: one long hold-off, a calm phase, random stalls elsewhere.
	initial begin : rsp_drive
		int  hold_left;
		bit  hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				rsp_ch.ready <= 1'b0;
				hold_left--;
			end else if (phase_no == HOLD_PHASE && !hold_used) begin
				hold_used = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else if (phase_no == CALM_PHASE) begin
				rsp_ch.ready <= 1'b1;
			end else begin
				rsp_ch.ready <= ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	// Offer one item, idling first at random, and return once it is taken.
	task automatic send_item(arp_req_t r, pinned_rsp_t pin);
		if (phase_no != CALM_PHASE) begin
			while ($urandom_range(0, 99) < IDLE_PCT) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		pinned_q.push_back(pin);
		req_ch.valid <= 1'b1;
		req_ch.opcode <= r.opcode;
		req_ch.ip_addr <= r.ip_addr;
		req_ch.mac_addr <= r.mac_addr;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) begin
			@(posedge clk);
		end
	endtask

	// Hold the input until every outstanding result is back or the wait limit is reached.
	task automatic settle_results();
		int unsigned waited;
		waited = 0;
		req_ch.valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (results_due.size() != 0 && waited < SETTLE_LIMIT);
	endtask

	task automatic set_timeout(logic [TIMEOUT_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		age_limit = value;
	endtask

	// Mostly addresses from a small pool so lookups hit and duplicates occur.
	function automatic arp_req_t random_request();
		arp_req_t    r;
		int unsigned pick;
		pick = $urandom_range(0, 99);
		r.mac_addr = MAC_W'({$urandom(), $urandom()});
		if ($urandom_range(0, 3) == 0) begin
			r.ip_addr = $urandom();
		end else begin
			r.ip_addr = ip_pool[$urandom_range(0, POOL_N - 1)];
		end
		if (pick < 40) begin
			r.opcode = OP_LOOKUP;
		end else if (pick < 72) begin
			r.opcode = OP_INSERT;
		end else if (pick < 93) begin
			r.opcode = OP_TICK;
		end else begin
			r.opcode = OP_RSVD;
		end
		return r;
	endfunction

	function automatic logic [TIMEOUT_W-1:0] phase_timeout(int ph);
		case (ph)
			2, 7:    return TIMEOUT_W'(1);
			3:       return '1;
			4:       return '0;
			5:       return TIMEOUT_W'($urandom_range(2, 40));
			default: return TIMEOUT_W'($urandom_range(1, 65535));
		endcase
	endfunction

	initial begin : stimulus
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_LOOKUP;
		req_ch.ip_addr <= '0;
		req_ch.mac_addr <= '0;
		err_count = 0;
		phase_no = 0;
		now_tick = '0;
		age_limit = TIMEOUT_RESET;
		foreach (row_valid[i]) begin
			row_valid[i] = 1'b0;
			row_ip[i] = '0;
			row_mac[i] = '0;
			row_added[i] = '0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// Walk the directed table under the reset timeout.
		for (int k = 0; k < DIRECTED_N; k++) begin
			send_item(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].want);
		end

		// Random phases; from phase 2 on each sets its own timeout once the block is idle.
		for (int ph = 1; ph <= LAST_PHASE; ph++) begin
			settle_results();
			repeat (4) @(posedge clk);
			if (ph != 1) begin
				set_timeout(phase_timeout(ph));
			end
			phase_no = ph;
			foreach (ip_pool[i]) begin
				ip_pool[i] = $urandom();
			end
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n == PHASE_ITEMS / 2) begin
					settle_results();
				end
				send_item(random_request(), '0);
			end
		end

		// Drain, then watch for stray results.
		settle_results();
		repeat (2 * (ENTRIES + 3)) @(posedge clk);
		if (results_due.size() != 0) begin
			log_fault($sformatf("%0d expected results never arrived", results_due.size()));
		end
		if (err_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
